### sv/four_channel_overwrite_sample_ring_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample ring unit
// Clocked, reset-qualified property helpers used by the top level.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_OVERWRITE_SAMPLE_RING_UNIT_DEFINES_SVH
`define FOUR_CHANNEL_OVERWRITE_SAMPLE_RING_UNIT_DEFINES_SVH

// same-cycle implication
`define FWSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fwsr assertion failed");

// next-cycle implication
`define FWSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fwsr assertion failed");

`endif

### sv/fwsr_pkg.sv
// ----------------------------------------------------------------------------
// fwsr_pkg
// Shared constants and types of the four-channel overwriting sample ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwsr_pkg;

    localparam int RING_DEPTH = 16384;
    localparam int HEAD_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = HEAD_W + 1;
    localparam int NUM_LANES  = 4;
    localparam int LANE_W     = $clog2(NUM_LANES);
    localparam int SAMPLE_W   = 12;
    localparam int WORD_W     = 16;
    localparam int RATE_W     = 27;
    localparam int GEN_W      = 32;
    localparam int CHAN_W     = 3;
    localparam int MODE_W     = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH     = 3'd0,
        MODE_SNAPSHOT = 3'd1,
        MODE_READ     = 3'd2,
        MODE_CLEAR    = 3'd3,
        MODE_MARK     = 3'd4,
        MODE_TAKE     = 3'd5
    } mode_t;

    typedef struct packed {
        logic              wr_en;
        logic [HEAD_W-1:0] wr_addr;
        logic              rd_en;
        logic [HEAD_W-1:0] rd_addr;
    } lane_ctrl_t;

endpackage

### sv/fwsr_ram.sv
// ----------------------------------------------------------------------------
// fwsr_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwsr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/fwsr_lane.sv
// ----------------------------------------------------------------------------
// fwsr_lane
// One channel lane: trims the raw word to a sample and keeps its ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwsr_lane
    import fwsr_pkg::*;
(
    input  logic                aclk,
    input  lane_ctrl_t          ctrl,
    input  logic [WORD_W-1:0]   word,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] sample;

    // only the low bits of the raw word carry the sample
    assign sample = word[SAMPLE_W-1:0];

    fwsr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctrl.wr_en),
        .waddr (ctrl.wr_addr),
        .wdata (sample),
        .re    (ctrl.rd_en),
        .raddr (ctrl.rd_addr),
        .rdata (rd_data)
    );

endmodule

### sv/fwsr_merge.sv
// ----------------------------------------------------------------------------
// fwsr_merge
// Combines the lane read results into the one reported sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwsr_merge
    import fwsr_pkg::*;
(
    input  logic [SAMPLE_W-1:0] lane_data [NUM_LANES],
    input  logic [LANE_W-1:0]   lane_sel,
    input  logic                sample_ok,
    output logic [SAMPLE_W-1:0] sample
);

    always_comb begin
        sample = '0;
        if (sample_ok) begin
            sample = lane_data[lane_sel];
        end
    end

endmodule

### sv/four_channel_overwrite_sample_ring_unit.sv
// ----------------------------------------------------------------------------
// Pipeline: a transaction passes the stage-1 register (the lane RAM read is
// registered there) and then the output register, where the merged result lands.
// Throughput: one transaction per cycle while stage 1 can advance; s_ready
// drops when stage 1 is full and the output register is stalled.
// Reset: synchronous active-low aresetn clears head, count, rate, flag, snapshot
// and pipeline valids; generation resets to one. Ring RAMs are not cleared.
// ----------------------------------------------------------------------------
// four_channel_overwrite_sample_ring_unit
// Four-lane overwriting history ring with snapshot-relative reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "four_channel_overwrite_sample_ring_unit_defines.svh"

module four_channel_overwrite_sample_ring_unit
    import fwsr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [WORD_W-1:0]   s_word_ch1,
    input  logic [WORD_W-1:0]   s_word_ch2,
    input  logic [WORD_W-1:0]   s_word_ch3,
    input  logic [WORD_W-1:0]   s_word_ch4,
    input  logic                s_block_last,
    input  logic [RATE_W-1:0]   s_rate_in,
    input  logic [CHAN_W-1:0]   s_read_channel,
    input  logic [CNT_W-1:0]    s_visual_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_sample_out,
    output logic [CNT_W-1:0]    m_count_out,
    output logic [HEAD_W-1:0]   m_head_out,
    output logic [GEN_W-1:0]    m_generation_out,
    output logic [RATE_W-1:0]   m_rate_out,
    output logic                m_cycle_done_out,
    output logic                m_status
);

    localparam logic [CNT_W:0]    DEPTH_EXT  = (CNT_W + 1)'(RING_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(RING_DEPTH);
    localparam logic [HEAD_W-1:0] HEAD_LAST  = HEAD_W'(RING_DEPTH - 1);

    // architectural state
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [GEN_W-1:0]  gen_reg, gen_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic              flag_reg, flag_next;
    logic [HEAD_W-1:0] snap_head_reg, snap_head_next;
    logic [CNT_W-1:0]  snap_cnt_reg, snap_cnt_next;

    // stage 1: scalar results wait for lane read data
    logic              p1_valid_reg, p1_valid_next;
    logic [CNT_W-1:0]  p1_count_reg;
    logic [HEAD_W-1:0] p1_head_reg;
    logic [GEN_W-1:0]  p1_gen_reg;
    logic [RATE_W-1:0] p1_rate_reg;
    logic              p1_flag_reg, p1_flag_next;
    logic              p1_status_reg, p1_status_next;
    logic              p1_ok_reg, p1_ok_next;
    logic [LANE_W-1:0] p1_lane_reg;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_sample_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic [HEAD_W-1:0] m_head_reg;
    logic [GEN_W-1:0]  m_gen_reg;
    logic [RATE_W-1:0] m_rate_reg;
    logic              m_flag_reg;
    logic              m_status_reg;

    logic              s_acc;
    logic              p1_adv;
    mode_t             mode;
    logic              push_ok;
    logic [CNT_W:0]    wr_sum;
    logic [CNT_W:0]    rd_sum;
    logic [HEAD_W-1:0] wr_slot;
    logic [HEAD_W-1:0] rd_slot;
    lane_ctrl_t        lane_ctrl;
    logic [WORD_W-1:0] lane_word [NUM_LANES];
    logic [SAMPLE_W-1:0] lane_data [NUM_LANES];
    logic [SAMPLE_W-1:0] merged;

    assign mode    = mode_t'(s_mode);
    assign p1_adv  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_adv;
    assign s_acc   = s_valid && s_ready;
    assign push_ok = (mode == MODE_PUSH) && (s_rate_in != '0);

    // sums that address a real access stay below twice the depth, so one
    // subtract wraps them
    always_comb begin
        wr_sum  = {1'b0, fill_reg} + (CNT_W + 1)'(head_reg);
        wr_slot = head_reg;
        if (fill_reg < DEPTH_CNT) begin
            if (wr_sum >= DEPTH_EXT) begin
                wr_slot = HEAD_W'(wr_sum - DEPTH_EXT);
            end else begin
                wr_slot = wr_sum[HEAD_W-1:0];
            end
        end
        rd_sum = {1'b0, s_visual_index} + (CNT_W + 1)'(snap_head_reg);
        if (rd_sum >= DEPTH_EXT) begin
            rd_slot = HEAD_W'(rd_sum - DEPTH_EXT);
        end else begin
            rd_slot = rd_sum[HEAD_W-1:0];
        end
    end

    always_comb begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        gen_next       = gen_reg;
        rate_next      = rate_reg;
        flag_next      = flag_reg;
        snap_head_next = snap_head_reg;
        snap_cnt_next  = snap_cnt_reg;
        p1_status_next = 1'b0;
        p1_ok_next     = 1'b0;
        p1_flag_next   = flag_reg;
        lane_ctrl.wr_en   = 1'b0;
        lane_ctrl.wr_addr = wr_slot;
        lane_ctrl.rd_en   = 1'b0;
        lane_ctrl.rd_addr = rd_slot;
        if (s_acc) begin
            case (mode)
                MODE_PUSH: begin
                    if (push_ok) begin
                        lane_ctrl.wr_en = 1'b1;
                        if (fill_reg < DEPTH_CNT) begin
                            fill_next = fill_reg + 1'b1;
                        end else if (head_reg == HEAD_LAST) begin
                            head_next = '0;
                        end else begin
                            head_next = head_reg + 1'b1;
                        end
                        if (s_block_last) begin
                            rate_next = s_rate_in;
                        end
                    end else begin
                        p1_status_next = 1'b1;
                    end
                end
                MODE_SNAPSHOT: begin
                    snap_head_next = head_reg;
                    snap_cnt_next  = fill_reg;
                end
                MODE_READ: begin
                    p1_ok_next = (s_read_channel < CHAN_W'(NUM_LANES))
                              && (s_visual_index < snap_cnt_reg);
                    lane_ctrl.rd_en = p1_ok_next;
                end
                MODE_CLEAR: begin
                    head_next = '0;
                    fill_next = '0;
                    rate_next = '0;
                    flag_next = 1'b0;
                    gen_next  = gen_reg + 1'b1;
                end
                MODE_MARK: begin
                    flag_next = 1'b1;
                end
                MODE_TAKE: begin
                    // report the flag as it was, then drop it
                    flag_next = 1'b0;
                end
                default: begin
                    p1_status_next = 1'b1;
                end
            endcase
            if (mode != MODE_TAKE) begin
                p1_flag_next = flag_next;
            end
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_acc) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            fill_reg      <= '0;
            gen_reg       <= GEN_W'(1);
            rate_reg      <= '0;
            flag_reg      <= 1'b0;
            snap_head_reg <= '0;
            snap_cnt_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            gen_reg       <= gen_next;
            rate_reg      <= rate_next;
            flag_reg      <= flag_next;
            snap_head_reg <= snap_head_next;
            snap_cnt_reg  <= snap_cnt_next;
            p1_valid_reg  <= p1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_count_reg  <= fill_next;
            p1_head_reg   <= head_next;
            p1_gen_reg    <= gen_next;
            p1_rate_reg   <= rate_next;
            p1_flag_reg   <= p1_flag_next;
            p1_status_reg <= p1_status_next;
            p1_ok_reg     <= p1_ok_next;
            p1_lane_reg   <= s_read_channel[LANE_W-1:0];
        end
        if (p1_adv) begin
            m_sample_reg <= merged;
            m_count_reg  <= p1_count_reg;
            m_head_reg   <= p1_head_reg;
            m_gen_reg    <= p1_gen_reg;
            m_rate_reg   <= p1_rate_reg;
            m_flag_reg   <= p1_flag_reg;
            m_status_reg <= p1_status_reg;
        end
    end

    assign lane_word[0] = s_word_ch1;
    assign lane_word[1] = s_word_ch2;
    assign lane_word[2] = s_word_ch3;
    assign lane_word[3] = s_word_ch4;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        fwsr_lane u_lane (
            .aclk    (aclk),
            .ctrl    (lane_ctrl),
            .word    (lane_word[g]),
            .rd_data (lane_data[g])
        );
    end

    fwsr_merge u_merge (
        .lane_data (lane_data),
        .lane_sel  (p1_lane_reg),
        .sample_ok (p1_ok_reg),
        .sample    (merged)
    );

    assign m_valid          = m_valid_reg;
    assign m_sample_out     = m_sample_reg;
    assign m_count_out      = m_count_reg;
    assign m_head_out       = m_head_reg;
    assign m_generation_out = m_gen_reg;
    assign m_rate_out       = m_rate_reg;
    assign m_cycle_done_out = m_flag_reg;
    assign m_status         = m_status_reg;

    `FWSR_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= DEPTH_CNT)
    `FWSR_ASSERT_NEXT(a_full_stays, aclk, aresetn,
                      s_acc && push_ok && fill_reg == DEPTH_CNT, fill_reg == DEPTH_CNT)
    `FWSR_ASSERT_NEXT(a_clear_empties, aclk, aresetn, s_acc && mode == MODE_CLEAR,
                      fill_reg == '0 && head_reg == '0)
    // head only moves once the ring is full
    `FWSR_ASSERT_NOW(a_head_empty, aclk, aresetn, fill_reg < DEPTH_CNT, head_reg == '0)

endmodule

### dv/tb_four_channel_overwrite_sample_ring_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_channel_overwrite_sample_ring_unit
// Self-checking bench for the four-channel overwriting sample ring. A driver
// and a monitor run as clocked always blocks. The driver sends frames, snapshots,
// reads and control transactions with random bursts and gaps, and the receiver
// stalls on rotating patterns. Every accepted transaction runs through a
// shadow ring, and every result is compared field by field in order.
// ----------------------------------------------------------------------------

module tb_four_channel_overwrite_sample_ring_unit;
    import fwsr_pkg::*;

    typedef struct packed {
        mode_t                            mode;
        logic [NUM_LANES-1:0][WORD_W-1:0] words;
        logic                             block_last;
        logic [RATE_W-1:0]                rate;
        logic [CHAN_W-1:0]                chan;
        logic [CNT_W-1:0]                 vidx;
        logic                             hold_off;
    } frame_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CNT_W-1:0]    count;
        logic [HEAD_W-1:0]   head;
        logic [GEN_W-1:0]    generation;
        logic [RATE_W-1:0]   rate;
        logic                cycle_done;
        logic                status;
    } ring_result_t;

    localparam int MAX_RATE    = 100000000;
    localparam int RATE_TOPBIT = 67108864;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode         = '0;
    logic [WORD_W-1:0]   s_word_ch1     = '0;
    logic [WORD_W-1:0]   s_word_ch2     = '0;
    logic [WORD_W-1:0]   s_word_ch3     = '0;
    logic [WORD_W-1:0]   s_word_ch4     = '0;
    logic                s_block_last   = 1'b0;
    logic [RATE_W-1:0]   s_rate_in      = '0;
    logic [CHAN_W-1:0]   s_read_channel = '0;
    logic [CNT_W-1:0]    s_visual_index = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [SAMPLE_W-1:0] m_sample_out;
    logic [CNT_W-1:0]    m_count_out;
    logic [HEAD_W-1:0]   m_head_out;
    logic [GEN_W-1:0]    m_generation_out;
    logic [RATE_W-1:0]   m_rate_out;
    logic                m_cycle_done_out;
    logic                m_status;

    four_channel_overwrite_sample_ring_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_word_ch1       (s_word_ch1),
        .s_word_ch2       (s_word_ch2),
        .s_word_ch3       (s_word_ch3),
        .s_word_ch4       (s_word_ch4),
        .s_block_last     (s_block_last),
        .s_rate_in        (s_rate_in),
        .s_read_channel   (s_read_channel),
        .s_visual_index   (s_visual_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_out     (m_sample_out),
        .m_count_out      (m_count_out),
        .m_head_out       (m_head_out),
        .m_generation_out (m_generation_out),
        .m_rate_out       (m_rate_out),
        .m_cycle_done_out (m_cycle_done_out),
        .m_status         (m_status)
    );

    // shadow ring
    logic [SAMPLE_W-1:0] lane_mem [NUM_LANES][RING_DEPTH];
    int unsigned         hist_head    = 0;
    int unsigned         hist_fill    = 0;
    int unsigned         snap_head_q  = 0;
    int unsigned         snap_fill_q  = 0;
    logic [RATE_W-1:0]   frame_rate_q = '0;
    logic [GEN_W-1:0]    gen_q        = 32'd1;
    logic                done_flag_q  = 1'b0;

    frame_item_t  pending_frames[$];
    ring_result_t expected_results[$];
    frame_item_t  drive_item;
    frame_item_t  seen_item;
    int unsigned  total_items  = 0;
    int unsigned  accepted_cnt = 0;
    int unsigned  err_cnt      = 0;
    bit           in_taken     = 1'b0;

    // fill level the generator expects, used to aim read indices
    int unsigned  plan_fill = 0;
    int unsigned  plan_snap = 0;

    int unsigned  burst_left = 1;
    int unsigned  gap_left   = 0;
    logic [15:0]  stall_pat  = 16'hFFFF;
    int unsigned  pat_left   = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(1_000_000);
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < 100) $display("%0t: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic ring_result_t predict_ring(input frame_item_t it);
        ring_result_t r;
        int unsigned  slot;
        r = '0;
        case (it.mode)
            MODE_PUSH: begin
                if (it.rate == '0) begin
                    r.status = 1'b1;
                end else begin
                    if (hist_fill < RING_DEPTH) begin
                        slot = (hist_head + hist_fill) % RING_DEPTH;
                        hist_fill++;
                    end else begin
                        // full: overwrite oldest and advance head
                        slot = hist_head;
                        hist_head = (hist_head + 1) % RING_DEPTH;
                    end
                    for (int c = 0; c < NUM_LANES; c++) begin
                        lane_mem[c][slot] = it.words[c][SAMPLE_W-1:0];
                    end
                    if (it.block_last) frame_rate_q = it.rate;
                end
            end
            MODE_SNAPSHOT: begin
                snap_head_q = hist_head;
                snap_fill_q = hist_fill;
            end
            MODE_READ: begin
                if (it.chan < NUM_LANES && it.vidx < snap_fill_q) begin
                    r.sample = lane_mem[it.chan][(snap_head_q + it.vidx) % RING_DEPTH];
                end
            end
            MODE_CLEAR: begin
                hist_head    = 0;
                hist_fill    = 0;
                frame_rate_q = '0;
                done_flag_q  = 1'b0;
                gen_q        = gen_q + 1'b1;
            end
            MODE_MARK: done_flag_q = 1'b1;
            MODE_TAKE: ;
            default:   r.status = 1'b1;
        endcase
        r.cycle_done = done_flag_q;
        if (it.mode == MODE_TAKE) done_flag_q = 1'b0;
        r.count      = CNT_W'(hist_fill);
        r.head       = HEAD_W'(hist_head);
        r.generation = gen_q;
        r.rate       = frame_rate_q;
        return r;
    endfunction

    task automatic check_result(input ring_result_t want);
        if (m_sample_out !== want.sample)
            report_mismatch($sformatf("sample_out got %0h expected %0h",
                                      m_sample_out, want.sample));
        if (m_count_out !== want.count)
            report_mismatch($sformatf("count_out got %0d expected %0d",
                                      m_count_out, want.count));
        if (m_head_out !== want.head)
            report_mismatch($sformatf("head_out got %0d expected %0d",
                                      m_head_out, want.head));
        if (m_generation_out !== want.generation)
            report_mismatch($sformatf("generation_out got %0d expected %0d",
                                      m_generation_out, want.generation));
        if (m_rate_out !== want.rate)
            report_mismatch($sformatf("rate_out got %0d expected %0d",
                                      m_rate_out, want.rate));
        if (m_cycle_done_out !== want.cycle_done)
            report_mismatch($sformatf("cycle_done_out got %0b expected %0b",
                                      m_cycle_done_out, want.cycle_done));
        if (m_status !== want.status)
            report_mismatch($sformatf("status got %0b expected %0b",
                                      m_status, want.status));
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return RATE_W'(1);
            1:       return RATE_W'(MAX_RATE);
            2:       return RATE_W'($urandom_range(1, 1000));
            3:       return RATE_W'($urandom_range(RATE_TOPBIT, MAX_RATE));
            default: return RATE_W'($urandom_range(1, MAX_RATE));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_index();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (plan_snap == 0 || sel == 0) return CNT_W'($urandom_range(0, RING_DEPTH));
        if (sel == 1) return CNT_W'(plan_snap);
        if (sel == 2) return CNT_W'(plan_snap - 1);
        return CNT_W'($urandom_range(0, plan_snap - 1));
    endfunction

    function automatic frame_item_t random_item(input mode_t m);
        frame_item_t it;
        it.mode = m;
        for (int c = 0; c < NUM_LANES; c++) it.words[c] = WORD_W'($urandom);
        it.block_last = 1'($urandom_range(0, 1));
        it.rate       = pick_rate();
        it.chan       = ($urandom_range(0, 4) == 0) ? CHAN_W'($urandom_range(4, 7))
                                                    : CHAN_W'($urandom_range(0, 3));
        it.vidx       = pick_index();
        it.hold_off   = 1'b0;
        return it;
    endfunction

    task automatic queue_item(input frame_item_t it);
        case (it.mode)
            MODE_PUSH:     if (it.rate != '0 && plan_fill < RING_DEPTH) plan_fill++;
            MODE_SNAPSHOT: plan_snap = plan_fill;
            MODE_CLEAR:    plan_fill = 0;
            default: ;
        endcase
        pending_frames.push_back(it);
    endtask

    task automatic queue_read(input int unsigned chan, input int unsigned idx);
        frame_item_t it;
        it      = random_item(MODE_READ);
        it.chan = CHAN_W'(chan);
        it.vidx = CNT_W'(idx);
        queue_item(it);
    endtask

    // mostly well-formed blocks followed by an optional snapshot and reads, plus noise
    task automatic queue_random_traffic(input int unsigned n_items);
        frame_item_t       it;
        int unsigned       start;
        int unsigned       n;
        logic [RATE_W-1:0] blk_rate;
        start = pending_frames.size();
        while (pending_frames.size() - start < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    n = $urandom_range(1, 8);
                    blk_rate = pick_rate();
                    for (int i = 0; i < n; i++) begin
                        it = random_item(MODE_PUSH);
                        it.rate = ($urandom_range(0, 19) == 0) ? '0 : blk_rate;
                        it.block_last = (i == n - 1);
                        queue_item(it);
                    end
                    if ($urandom_range(0, 3) != 0) queue_item(random_item(MODE_SNAPSHOT));
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) queue_item(random_item(MODE_READ));
                end
                6: begin
                    case ($urandom_range(0, 2))
                        0:       queue_item(random_item(MODE_MARK));
                        1:       queue_item(random_item(MODE_TAKE));
                        default: queue_item(random_item(MODE_CLEAR));
                    endcase
                end
                default: begin
                    // includes the two unused mode codes
                    it = random_item(mode_t'($urandom_range(0, 7)));
                    if (it.mode == MODE_PUSH && $urandom_range(0, 3) == 0) it.rate = '0;
                    if ($urandom_range(0, 99) == 0) it.hold_off = 1'b1;
                    queue_item(it);
                end
            endcase
        end
    endtask

    initial begin
        frame_item_t it;

        // directed: empty snapshot, rejected push, field extremes
        queue_read(0, 0);
        it = random_item(MODE_PUSH);
        it.words = {4{16'hFFFF}};
        it.rate = '0;
        it.block_last = 1'b1;
        queue_item(it);
        it = random_item(MODE_PUSH);
        it.words = {4{16'hFFFF}};
        it.rate = RATE_W'(1);
        it.block_last = 1'b0;
        queue_item(it);
        it = random_item(MODE_PUSH);
        it.words = '0;
        it.rate = RATE_W'(MAX_RATE);
        it.block_last = 1'b1;
        queue_item(it);
        it = random_item(MODE_PUSH);
        it.words = {16'h5A5A, 16'hA5A5, 16'h0F0F, 16'hF0F0};
        it.rate = RATE_W'(RATE_TOPBIT);
        it.block_last = 1'b1;
        queue_item(it);
        queue_item(random_item(MODE_SNAPSHOT));
        queue_read(0, 0);
        queue_read(1, 1);
        queue_read(3, 2);
        queue_read(2, 3);
        queue_read(4, 0);
        queue_read(7, 1);
        queue_read(0, RING_DEPTH);
        queue_item(random_item(MODE_MARK));
        queue_item(random_item(MODE_TAKE));
        queue_item(random_item(MODE_TAKE));
        queue_item(random_item(MODE_MARK));
        it = random_item(MODE_CLEAR);
        it.hold_off = 1'b1;
        queue_item(it);
        // stale snapshot still reads the kept ring contents
        queue_read(3, 2);
        queue_item(random_item(MODE_SNAPSHOT));
        queue_read(0, 0);

        queue_random_traffic(512);
        queue_random_traffic(512);
        total_items = pending_frames.size();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < total_items) @(negedge aclk);
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // driver: bursts with random gaps; a held-off transaction waits for a drain
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (gap_left != 0 || pending_frames.size() == 0 ||
                (pending_frames[0].hold_off && expected_results.size() != 0)) begin
                if (gap_left != 0) gap_left--;
                s_valid <= 1'b0;
            end else begin
                drive_item = pending_frames.pop_front();
                s_valid        <= 1'b1;
                s_mode         <= drive_item.mode;
                s_word_ch1     <= drive_item.words[0];
                s_word_ch2     <= drive_item.words[1];
                s_word_ch3     <= drive_item.words[2];
                s_word_ch4     <= drive_item.words[3];
                s_block_last   <= drive_item.block_last;
                s_rate_in      <= drive_item.rate;
                s_read_channel <= drive_item.chan;
                s_visual_index <= drive_item.vidx;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 128)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver backpressure from a rotating pattern
    always @(negedge aclk) begin
        if (pat_left == 0) begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pat = 16'hFFFF;
                2:       stall_pat = 16'($urandom) | 16'h0001;
                3:       stall_pat = 16'h00FF;
                default: stall_pat = 16'h8001;
            endcase
            pat_left = $urandom_range(16, 200);
        end
        pat_left--;
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        m_ready <= stall_pat[0];
    end

    // monitor: check results first, then log the accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: count %0d head %0d",
                                              m_count_out, m_head_out));
                end else begin
                    check_result(expected_results.pop_front());
                end
            end
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                seen_item.mode       = mode_t'(s_mode);
                seen_item.words      = {s_word_ch4, s_word_ch3, s_word_ch2, s_word_ch1};
                seen_item.block_last = s_block_last;
                seen_item.rate       = s_rate_in;
                seen_item.chan       = s_read_channel;
                seen_item.vidx       = s_visual_index;
                seen_item.hold_off   = 1'b0;
                expected_results.push_back(predict_ring(seen_item));
                accepted_cnt++;
            end
        end
    end

endmodule

### four_channel_overwrite_sample_ring_unit.f
+incdir+sv
sv/fwsr_pkg.sv
sv/fwsr_ram.sv
sv/fwsr_lane.sv
sv/fwsr_merge.sv
sv/four_channel_overwrite_sample_ring_unit.sv
dv/tb_four_channel_overwrite_sample_ring_unit.sv
